// ===== hdl/cwd_pkg.sv =====
// shared constants and codes for the count-weighted draw block
`default_nettype none

package cwd_pkg;

    // default sizes of the count table and the random fraction
    localparam int DEF_MAX_CELLS   = 64;
    localparam int DEF_COUNT_BITS  = 16;
    localparam int DEF_RANDOM_BITS = 32;

    // input word fields
    localparam int CELL_W      = 6;
    localparam int CNT_FIELD_W = 16;
    localparam int RND_FIELD_W = 32;
    localparam int CELL_LSB    = 0;
    localparam int CNT_LSB     = CELL_LSB + CELL_W;
    localparam int RND_LSB     = CNT_LSB + CNT_FIELD_W;
    localparam int S_TDATA_W   = 56;
    localparam int S_TUSER_W   = 1;

    // result word fields
    localparam int OUT_W       = 6;
    localparam int OCELL_LSB   = 0;
    localparam int OROW_LSB    = OCELL_LSB + OUT_W;
    localparam int OCOL_LSB    = OROW_LSB + OUT_W;
    localparam int M_TDATA_W   = 24;
    localparam int M_TUSER_W   = 1;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;
    localparam int COL_W       = 7;

    localparam logic [CFG_INDEX_W-1:0] REG_USED_CELLS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 2'd1;

    localparam logic [CFG_DATA_W-1:0] USED_CELLS_RESET   = 7'd64;
    localparam logic [CFG_DATA_W-1:0] COLUMN_COUNT_RESET = 7'd8;

    // item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_DRAW = 1'b1;

endpackage

`default_nettype wire

// ===== hdl/count_weighted_draw_without_replacement_core.sv =====
// top level: count table, draw sequencer with shift-add multiply, row/column split
//
// Input words arrive on s_tvalid/s_tready. s_tuser selects the kind: a load
// writes one cell's count in the cycle it is accepted and gives no result; a
// draw gives exactly one result word on m_tvalid/m_tready.
// Registers are written on cfg_valid/cfg_ready (always ready): index 0 is the
// number of cells in use, index 1 the columns per row.
// A draw over n used cells walks the table once to total the counts, forms r
// times the total one bit of r per cycle, walks the cumulative counts again
// until the chosen cell (the last nonzero used cell always qualifies), writes
// back the decremented count and splits the cell into row and column one
// quotient bit per cycle, then loads the output register. The next input word
// can be taken in the same cycle as the result word turns valid, so one draw
// is finished before the next input word is taken. An empty table goes from
// the total straight to loading the output register.
// After reset a clearing pass zeroes every cell of the table with
// s_tready low; configuration writes are taken meanwhile.
// A result held by a stalled receiver stays in the output register; loads and
// a new draw are still accepted, and a finished draw waits in the push state
// until the output register is free.
`default_nettype none

module count_weighted_draw_without_replacement_core #(
    parameter int MAX_CELLS   = cwd_pkg::DEF_MAX_CELLS,
    parameter int COUNT_BITS  = cwd_pkg::DEF_COUNT_BITS,
    parameter int RANDOM_BITS = cwd_pkg::DEF_RANDOM_BITS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input words
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [5:0] cell_req, [21:6] count_value, [53:22] random_fraction, [55:54] zero
    input  wire logic [cwd_pkg::S_TDATA_W-1:0]     s_tdata,
    // [0] kind
    input  wire logic [cwd_pkg::S_TUSER_W-1:0]     s_tuser,
    // result words
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [5:0] chosen_cell, [11:6] chosen_row, [17:12] chosen_column, [23:18] zero
    output logic [cwd_pkg::M_TDATA_W-1:0]          m_tdata,
    // [0] empty_res
    output logic [cwd_pkg::M_TUSER_W-1:0]          m_tuser,
    // configuration writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [cwd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [cwd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int AW = $clog2(MAX_CELLS);
    localparam int CW = $clog2(MAX_CELLS + 1);
    localparam int TW = COUNT_BITS + AW;
    localparam int PW = TW + RANDOM_BITS;
    localparam int MW = $clog2(RANDOM_BITS + 1);
    localparam int UW = (CW > cwd_pkg::CFG_DATA_W) ? CW : cwd_pkg::CFG_DATA_W;
    localparam int LW = CW + cwd_pkg::CELL_W;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_SUM   = 8'b0000_0100,
        ST_MUL   = 8'b0000_1000,
        ST_WALK  = 8'b0001_0000,
        ST_DEC   = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_PUSH  = 8'b1000_0000
    } state_t;

    state_t                          state_reg, state_next;
    logic [CW-1:0]                   idx_reg, idx_next;
    logic                            pend_reg, pend_next;
    logic [AW-1:0]                   data_idx_reg, data_idx_next;
    logic [TW-1:0]                   sum_reg, sum_next;
    logic [TW-1:0]                   cum_reg, cum_next;
    logic [PW-1:0]                   prod_reg, prod_next;
    logic [RANDOM_BITS-1:0]          r_reg, r_next;
    logic [MW-1:0]                   mcnt_reg, mcnt_next;
    logic [AW-1:0]                   pick_reg, pick_next;
    logic [COUNT_BITS-1:0]           hit_cnt_reg, hit_cnt_next;
    logic                            empty_reg, empty_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [cwd_pkg::M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                            m_empty_reg, m_empty_next;
    logic [cwd_pkg::CFG_DATA_W-1:0]  used_reg, used_next;
    logic [cwd_pkg::CFG_DATA_W-1:0]  column_reg, column_next;

    logic                            s_accept;
    logic                            s_kind;
    logic [cwd_pkg::CELL_W-1:0]      s_cell;
    logic [cwd_pkg::CNT_FIELD_W-1:0] s_count;
    logic [cwd_pkg::RND_FIELD_W-1:0] s_rnd;
    logic [UW-1:0]                   used_w;
    logic [CW-1:0]                   n_eff;
    logic [cwd_pkg::COL_W-1:0]       cols_eff;
    logic                            issue;
    logic [TW-1:0]                   cum_sum;
    logic                            hit;
    logic                            out_free;

    logic                            wr_en;
    logic [AW-1:0]                   wr_addr;
    logic [COUNT_BITS-1:0]           wr_data;
    logic [COUNT_BITS-1:0]           rd_data;

    logic                            div_start;
    logic                            div_busy;
    logic [AW-1:0]                   div_quot;
    logic [cwd_pkg::COL_W-1:0]       div_rem;

    // input word fields
    assign s_kind   = s_tuser[0];
    assign s_cell   = s_tdata[cwd_pkg::CELL_LSB +: cwd_pkg::CELL_W];
    assign s_count  = s_tdata[cwd_pkg::CNT_LSB +: cwd_pkg::CNT_FIELD_W];
    assign s_rnd    = s_tdata[cwd_pkg::RND_LSB +: cwd_pkg::RND_FIELD_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // clamped cell count and column count
    always_comb begin
        used_w = UW'(used_reg);
        if (used_reg == '0) begin
            n_eff = CW'(1);
        end else if (used_w > UW'(MAX_CELLS)) begin
            n_eff = CW'(MAX_CELLS);
        end else begin
            n_eff = CW'(used_w);
        end
        cols_eff = (column_reg == '0) ? cwd_pkg::COL_W'(1) : column_reg;
    end

    // walk compare: cumulative count times 2^RANDOM_BITS against r times total
    assign issue    = (idx_reg < n_eff);
    assign cum_sum  = cum_reg + TW'(rd_data);
    assign hit      = (rd_data != '0) && ({cum_sum, {RANDOM_BITS{1'b0}}} >= prod_reg);
    assign out_free = !m_tvalid_reg || m_tready;

    // table write port: clearing pass, loads, decrement after a draw
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = idx_reg[AW-1:0];
        wr_data = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                wr_en = 1'b1;
            end
            ST_IDLE: begin
                wr_en   = s_accept && (s_kind == cwd_pkg::KIND_LOAD) &&
                          (LW'(s_cell) < LW'(MAX_CELLS));
                wr_addr = AW'(s_cell);
                wr_data = COUNT_BITS'(s_count);
            end
            ST_DEC: begin
                wr_en   = 1'b1;
                wr_addr = pick_reg;
                wr_data = hit_cnt_reg - 1'b1;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign div_start = (state_reg == ST_DEC);

    // draw sequencer
    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        pend_next     = 1'b0;
        data_idx_next = idx_reg[AW-1:0];
        sum_next      = sum_reg;
        cum_next      = cum_reg;
        prod_next     = prod_reg;
        r_next        = r_reg;
        mcnt_next     = mcnt_reg;
        pick_next     = pick_reg;
        hit_cnt_next  = hit_cnt_reg;
        empty_next    = empty_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_empty_next  = m_empty_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == CW'(MAX_CELLS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept && (s_kind == cwd_pkg::KIND_DRAW)) begin
                    r_next     = RANDOM_BITS'(s_rnd);
                    idx_next   = '0;
                    sum_next   = '0;
                    empty_next = 1'b0;
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                // totals the used cells, reads pipelined one ahead
                if (issue) begin
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
                if (pend_reg) begin
                    sum_next = sum_reg + TW'(rd_data);
                end else if (!issue) begin
                    if (sum_reg == '0) begin
                        empty_next = 1'b1;
                        state_next = ST_PUSH;
                    end else begin
                        prod_next  = '0;
                        mcnt_next  = MW'(RANDOM_BITS);
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                // shift-add, most significant bit of r first
                prod_next = {prod_reg[PW-2:0], 1'b0} +
                            (r_reg[RANDOM_BITS-1] ? PW'(sum_reg) : PW'(0));
                r_next    = {r_reg[RANDOM_BITS-2:0], 1'b0};
                mcnt_next = mcnt_reg - 1'b1;
                if (mcnt_reg == MW'(1)) begin
                    idx_next   = '0;
                    cum_next   = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (issue) begin
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
                if (pend_reg) begin
                    cum_next     = cum_sum;
                    pick_next    = data_idx_reg;
                    hit_cnt_next = rd_data;
                    if (hit) begin
                        pend_next  = 1'b0;
                        state_next = ST_DEC;
                    end
                end else if (!issue) begin
                    // no hit: last used cell, already held
                    state_next = ST_DEC;
                end
            end
            ST_DEC: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (!div_busy) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_empty_next  = empty_reg;
                    m_tdata_next  = '0;
                    if (!empty_reg) begin
                        m_tdata_next[cwd_pkg::OCELL_LSB +: cwd_pkg::OUT_W] =
                            cwd_pkg::OUT_W'(pick_reg);
                        m_tdata_next[cwd_pkg::OROW_LSB +: cwd_pkg::OUT_W] =
                            cwd_pkg::OUT_W'(div_quot);
                        m_tdata_next[cwd_pkg::OCOL_LSB +: cwd_pkg::OUT_W] =
                            cwd_pkg::OUT_W'(div_rem);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // configuration registers
    always_comb begin
        used_next   = used_reg;
        column_next = column_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                cwd_pkg::REG_USED_CELLS:   used_next   = cfg_data;
                cwd_pkg::REG_COLUMN_COUNT: column_next = cfg_data;
                default: begin
                    used_next = used_reg;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            idx_reg      <= '0;
            pend_reg     <= 1'b0;
            mcnt_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            used_reg     <= cwd_pkg::USED_CELLS_RESET;
            column_reg   <= cwd_pkg::COLUMN_COUNT_RESET;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            pend_reg     <= pend_next;
            mcnt_reg     <= mcnt_next;
            m_tvalid_reg <= m_tvalid_next;
            used_reg     <= used_next;
            column_reg   <= column_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        data_idx_reg <= data_idx_next;
        sum_reg      <= sum_next;
        cum_reg      <= cum_next;
        prod_reg     <= prod_next;
        r_reg        <= r_next;
        pick_reg     <= pick_next;
        hit_cnt_reg  <= hit_cnt_next;
        empty_reg    <= empty_next;
        m_tdata_reg  <= m_tdata_next;
        m_empty_reg  <= m_empty_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = cwd_pkg::M_TUSER_W'(m_empty_reg);

    cwd_count_mem #(
        .DEPTH (MAX_CELLS),
        .WIDTH (COUNT_BITS)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    cwd_divider #(
        .DW (AW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (pick_reg),
        .divisor   (cols_eff),
        .busy      (div_busy),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

endmodule

`default_nettype wire

// ===== hdl/cwd_count_mem.sv =====
// count table memory, one write port and one registered read port
`default_nettype none

module cwd_count_mem #(
    parameter int DEPTH = cwd_pkg::DEF_MAX_CELLS,
    parameter int WIDTH = cwd_pkg::DEF_COUNT_BITS
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== hdl/cwd_divider.sv =====
// restoring divider, one quotient bit per cycle, splits a cell into row and column
`default_nettype none

module cwd_divider #(
    parameter int DW = 6
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic [DW-1:0]           dividend,
    input  wire logic [cwd_pkg::COL_W-1:0] divisor,
    output logic                         busy,
    output logic [DW-1:0]                quotient,
    output logic [cwd_pkg::COL_W-1:0]    remainder
);

    localparam int NW = $clog2(DW + 1);

    logic [NW-1:0]             cnt_reg, cnt_next;
    logic [DW-1:0]             q_reg, q_next;
    logic [cwd_pkg::COL_W-1:0] rem_reg, rem_next;
    logic [cwd_pkg::COL_W-1:0] div_reg, div_next;
    logic [cwd_pkg::COL_W:0]   rem_sh;
    logic [cwd_pkg::COL_W:0]   rem_sub;
    logic                      ge;
    logic [DW:0]               q_sh;

    // one shift-subtract step
    always_comb begin
        rem_sh  = {rem_reg, q_reg[DW-1]};
        rem_sub = rem_sh - {1'b0, div_reg};
        ge      = (rem_sh >= {1'b0, div_reg});
        q_sh    = {q_reg, ge};
    end

    always_comb begin
        cnt_next = cnt_reg;
        q_next   = q_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        if (start) begin
            cnt_next = NW'(DW);
            q_next   = dividend;
            rem_next = '0;
            div_next = divisor;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            q_next   = q_sh[DW-1:0];
            rem_next = ge ? rem_sub[cwd_pkg::COL_W-1:0] : rem_sh[cwd_pkg::COL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign busy      = (cnt_reg != '0);
    assign quotient  = q_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== hdl/cwd_checker.sv =====
// port-level assertions for the draw core, bound to the top level
`default_nettype none

module cwd_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [cwd_pkg::S_TUSER_W-1:0] s_tuser,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [cwd_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [cwd_pkg::M_TUSER_W-1:0] m_tuser
);

    // a stalled result word stays offered
    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    // a stalled result word keeps its payload
    a_data_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // an empty draw reports cell, row and column as zero
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("empty result carries nonzero fields");

    // a draw occupies the block, so input is not taken the next cycle
    a_draw_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == cwd_pkg::KIND_DRAW) |=> !s_tready)
        else $error("input taken right after a draw");

    // a load finishes in the cycle it is taken
    a_load_quick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == cwd_pkg::KIND_LOAD) |=> s_tready)
        else $error("load left the block busy");

endmodule

bind count_weighted_draw_without_replacement_core cwd_checker u_cwd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
